// ----- rtl/core/pva_pkg.sv -----
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types, constants and constant tables of the polyphonic voice
// allocator: voice entry layout, channel words, sine and phase step tables.
// ----------------------------------------------------------------------------
package pva_pkg;

  // Sizing
  localparam int VOICES       = 8;
  localparam int SAMPLE_RATE  = 48000;
  localparam int SINE_ENTRIES = 256;
  localparam int PHASE_BITS   = 32;
  localparam int NOTES        = 128;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SINE_W = $clog2(SINE_ENTRIES);
  localparam int ACC_W  = 16 + VIDX_W + 1;
  localparam int GAIN_W = 16;
  localparam int PROD_W = ACC_W + GAIN_W + 1;

  // Register map
  localparam int          PADDR_W       = 2;
  localparam int          PDATA_W       = 32;
  localparam logic [PADDR_W-1:0] REG_GAIN_ADDR = PADDR_W'(0);
  localparam logic [GAIN_W-1:0]  GAIN_RESET    = GAIN_W'(4096);

  // Command modes
  localparam logic [1:0] MODE_ON   = 2'd0;
  localparam logic [1:0] MODE_OFF  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // Output saturation bounds
  localparam int SAT_HI = 32767;
  localparam int SAT_LO = -32768;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] note;
  } pva_in_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [5:0]         voice;
    logic               voice_hit;
  } pva_out_t;

  // One voice as stored in the voice RAM
  typedef struct packed {
    logic [6:0]            pitch;
    logic [63:0]           age;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS-1:0] step;
  } pva_entry_t;

  // Outcome of one pass over the voice table
  typedef struct packed {
    logic                    free_found;
    logic [VIDX_W-1:0]       free_idx;
    logic                    same_found;
    logic [VIDX_W-1:0]       same_idx;
    logic [VIDX_W-1:0]       old_idx;
    logic                    hit_found;
    logic [VIDX_W-1:0]       hit_idx;
    pva_entry_t              hit_ent;
    logic signed [ACC_W-1:0] acc;
  } pva_srch_t;

  typedef logic [SINE_ENTRIES-1:0][15:0]   sine_tab_t;
  typedef logic [NOTES-1:0][PHASE_BITS-1:0] step_tab_t;

  // Q30 coefficients of sin(pi/2 * t)
  localparam logic [63:0] SC1 = 64'd1686629713;
  localparam logic [63:0] SC3 = 64'd693598668;
  localparam logic [63:0] SC5 = 64'd85569306;
  localparam logic [63:0] SC7 = 64'd5026995;
  localparam logic [63:0] SC9 = 64'd172272;

  // 2^(k/12) in Q16
  localparam logic [11:0][31:0] SEMI_Q16 = {
    32'd123715, 32'd116772, 32'd110218, 32'd104032, 32'd98193, 32'd92682,
    32'd87480,  32'd82570,  32'd77936,  32'd73562,  32'd69433, 32'd65536
  };

  // Quarter wave: t in Q30 over 0..1, result scaled to 32767
  function automatic logic [15:0] quarter_sine(logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] s;
    t2 = (t * t) >> 30;
    p  = SC9;
    p  = SC7 - ((t2 * p) >> 30);
    p  = SC5 - ((t2 * p) >> 30);
    p  = SC3 - ((t2 * p) >> 30);
    p  = SC1 - ((t2 * p) >> 30);
    s  = (t * p) >> 30;
    s  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] a;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] t;
    logic [15:0] v;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      a    = 64'(4 * i);
      quad = a / SINE_ENTRIES;
      rem  = a % SINE_ENTRIES;
      if (quad == 64'd1 || quad == 64'd3) begin
        rem = 64'(SINE_ENTRIES) - rem;
      end
      t      = (rem << 30) / SINE_ENTRIES;
      v      = quarter_sine(t);
      tab[i] = (quad >= 64'd2) ? (16'd0 - v) : v;
    end
    return tab;
  endfunction

  // Per-note phase step, equal temperament, note 69 at 440 Hz
  function automatic step_tab_t build_steps();
    step_tab_t   tab;
    int          m;
    int          oct;
    int          k;
    int          e;
    logic [63:0] num;
    logic [63:0] q;
    for (int n = 0; n < NOTES; n++) begin
      m   = n + 3;
      oct = m / 12;
      k   = m % 12;
      num = 64'd440 * 64'(SEMI_Q16[k]);
      e   = oct + PHASE_BITS - 22;
      if (e >= 0) begin
        q = ((num << e) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE);
      end else begin
        // rounded divide by SAMPLE_RATE * 2^-e: divide, then shift down
        q = ((num + ((64'(SAMPLE_RATE) << (-e)) >> 1)) / 64'(SAMPLE_RATE)) >> (-e);
      end
      tab[n] = q[PHASE_BITS-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam step_tab_t STEP_TAB = build_steps();

endpackage

// ----- rtl/core/pva_ram.sv -----
// ----------------------------------------------------------------------------
// pva_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/pva_search.sv -----
// ----------------------------------------------------------------------------
// pva_search
// Walks the voice entries streamed out of the voice RAM: finds the voice
// for a note-on, the voice to free on a note-off, or sums the sine of
// every active voice on a tick.
// ----------------------------------------------------------------------------
module pva_search
  import pva_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              ent_vld,
  input  logic [VIDX_W-1:0] ent_idx,
  input  pva_entry_t        ent,
  input  logic [1:0]        mode,
  input  logic [6:0]        note,
  output pva_srch_t         res
);

  logic                    free_found;
  logic [VIDX_W-1:0]       free_idx;
  logic                    same_found;
  logic [VIDX_W-1:0]       same_idx;
  logic [63:0]             same_age;
  logic [VIDX_W-1:0]       old_idx;
  logic [63:0]             old_age;
  logic                    hit_found;
  logic [VIDX_W-1:0]       hit_idx;
  logic [63:0]             newest;
  pva_entry_t              hit_ent;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0]      sine_val;
  logic                    busy_voice;
  logic                    pitch_eq;

  assign busy_voice = (ent.age != 64'd0);
  assign pitch_eq   = (ent.pitch == note);
  assign sine_val   = SINE_TAB[ent.phase[PHASE_BITS-1 -: SINE_W]];

  // Flags and accumulator
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      free_found <= 1'b0;
      same_found <= 1'b0;
      hit_found  <= 1'b0;
      same_age   <= '1;
      old_age    <= '1;
      newest     <= '0;
      acc        <= '0;
      old_idx    <= '0;
    end else if (ent_vld) begin
      case (mode)
        MODE_ON: begin
          // voices past the first free one are not looked at
          if (!free_found) begin
            if (!busy_voice) begin
              free_found <= 1'b1;
            end else begin
              if (pitch_eq && ent.age < same_age) begin
                same_found <= 1'b1;
                same_age   <= ent.age;
              end
              if (ent.age < old_age) begin
                old_age <= ent.age;
                old_idx <= ent_idx;
              end
            end
          end
        end
        MODE_OFF: begin
          if (pitch_eq && ent.age > newest) begin
            hit_found <= 1'b1;
            newest    <= ent.age;
          end
        end
        MODE_TICK: begin
          if (busy_voice) begin
            acc <= acc + ACC_W'(sine_val);
          end
        end
        default: ;
      endcase
    end
  end

  // Indices and captured entry
  always_ff @(posedge clk) begin
    if (ent_vld) begin
      if (mode == MODE_ON && !free_found) begin
        if (!busy_voice) begin
          free_idx <= ent_idx;
        end else if (pitch_eq && ent.age < same_age) begin
          same_idx <= ent_idx;
        end
      end
      if (mode == MODE_OFF && pitch_eq && ent.age > newest) begin
        hit_idx <= ent_idx;
        hit_ent <= ent;
      end
    end
  end

  always_comb begin
    res            = '0;
    res.free_found = free_found;
    res.free_idx   = free_idx;
    res.same_found = same_found;
    res.same_idx   = same_idx;
    res.old_idx    = old_idx;
    res.hit_found  = hit_found;
    res.hit_idx    = hit_idx;
    res.hit_ent    = hit_ent;
    res.acc        = acc;
  end

endmodule

// ----- rtl/core/pva_mix.sv -----
// ----------------------------------------------------------------------------
// pva_mix
// Scales the voice sum by the Q4.12 gain and saturates it to a 16-bit
// sample: the product is registered first, then the shift and clamp.
// ----------------------------------------------------------------------------
module pva_mix
  import pva_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [ACC_W-1:0] acc,
  input  logic [GAIN_W-1:0]       gain,
  output logic                    vld,
  output logic signed [15:0]      sample
);

  logic                     prod_vld;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= go;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      prod <= PROD_W'(acc) * $signed({1'b0, gain});
    end
  end

  // Floor divide by 4096, then clamp
  assign shifted = prod >>> 12;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      if (shifted > PROD_W'(SAT_HI)) begin
        sample <= 16'(SAT_HI);
      end else if (shifted < PROD_W'(SAT_LO)) begin
        sample <= 16'(SAT_LO);
      end else begin
        sample <= shifted[15:0];
      end
    end
  end

endmodule

// ----- rtl/core/polyphonic_voice_allocator_synth_core.sv -----
// ----------------------------------------------------------------------------
// polyphonic_voice_allocator_synth_core
// Voice allocator with table-sine oscillators. Voice state lives in one
// RAM that a sequencer scans once per command word.
//
//   channel   direction  handshake               word
//   -------   ---------  ----------------------  ------------------------
//   command   in         start high, busy low    cmd    {mode, note}
//   result    out        done strobe, 1 cycle    result {sample, voice, hit}
//   config    in         APB write, pready = 1   pwdata[15:0] output_gain
//
// A note word reads the RAM once per voice in order, waits out the read
// latency and lets the last search step settle, then does the write; a
// tick word does the gain multiply and then the clamp in place of the
// write. done shows in the cycle after the write or the clamp.
// busy stays high from accept until the cycle done is shown.
// Reset is synchronous; voice valid bits make every voice read as zero.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module polyphonic_voice_allocator_synth_core
  import pva_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pva_in_t            cmd,
  output logic               busy,
  output logic               done,
  output pva_out_t           result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_MUL  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [VIDX_W:0]     rd_cnt;
  logic                p_vld;
  logic [VIDX_W-1:0]   p_idx;
  logic                p_valid_bit;
  logic [1:0]          mode;
  logic [6:0]          note;
  logic [63:0]         age_stamp;
  logic [GAIN_W-1:0]   gain;
  logic [VOICES-1:0]   vld;
  logic                accept;
  logic                re;
  logic [VIDX_W-1:0]   raddr;
  logic [$bits(pva_entry_t)-1:0] rdata;
  pva_entry_t          ent;
  logic                we;
  logic [VIDX_W-1:0]   waddr;
  pva_entry_t          wdata;
  pva_srch_t           srch;
  logic [VIDX_W-1:0]   pick;
  logic                mix_go;
  logic                mix_vld;
  logic signed [15:0]  mix_sample;
  logic                note_done;
  pva_out_t            note_res;
  logic                cfg_wr;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_GAIN_ADDR) ? PDATA_W'(gain) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_wr && paddr == REG_GAIN_ADDR) begin
      gain <= pwdata[GAIN_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (rd_cnt == (VIDX_W+1)'(VOICES) && !p_vld) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        state_next = (mode == MODE_TICK) ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode <= cmd.mode;
      note <= cmd.note;
    end
  end

  // Read side: one voice per cycle
  assign re    = (state == S_SCAN) && (rd_cnt < (VIDX_W+1)'(VOICES));
  assign raddr = rd_cnt[VIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt <= '0;
      p_vld  <= 1'b0;
    end else begin
      p_vld <= re;
      if (accept) begin
        rd_cnt <= '0;
      end else if (re) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      p_idx       <= raddr;
      p_valid_bit <= vld[raddr];
    end
  end

  // Never-written voices read as zero
  assign ent = p_valid_bit ? pva_entry_t'(rdata) : '0;

  pva_ram #(
    .WIDTH ($bits(pva_entry_t)),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  pva_search u_search (
    .clk     (clk),
    .rst     (rst),
    .clr     (accept),
    .ent_vld (p_vld),
    .ent_idx (p_idx),
    .ent     (ent),
    .mode    (mode),
    .note    (note),
    .res     (srch)
  );

  // Voice chosen by a note-on
  always_comb begin
    if (srch.free_found) begin
      pick = srch.free_idx;
    end else if (srch.same_found) begin
      pick = srch.same_idx;
    end else begin
      pick = srch.old_idx;
    end
  end

  // Write side: phase advance during a tick scan, else one write at the end
  always_comb begin
    we    = 1'b0;
    waddr = p_idx;
    wdata = ent;
    if (p_vld && mode == MODE_TICK && ent.age != 64'd0) begin
      we          = 1'b1;
      wdata.phase = ent.phase + ent.step;
    end else if (state == S_FIN && mode == MODE_ON) begin
      we          = 1'b1;
      waddr       = pick;
      wdata.pitch = note;
      wdata.age   = age_stamp + 64'd1;
      wdata.phase = '0;
      wdata.step  = STEP_TAB[note];
    end else if (state == S_FIN && mode == MODE_OFF && srch.hit_found) begin
      we        = 1'b1;
      waddr     = srch.hit_idx;
      wdata     = srch.hit_ent;
      wdata.age = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      age_stamp <= '0;
    end else if (state == S_FIN && mode == MODE_ON) begin
      age_stamp <= age_stamp + 64'd1;
    end
  end

  // Gain and clamp for ticks
  assign mix_go = (state == S_FIN) && (mode == MODE_TICK);

  pva_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .go     (mix_go),
    .acc    (srch.acc),
    .gain   (gain),
    .vld    (mix_vld),
    .sample (mix_sample)
  );

  // Note-event result word
  always_ff @(posedge clk) begin
    if (rst) begin
      note_done <= 1'b0;
    end else begin
      note_done <= (state == S_FIN) && (mode != MODE_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      note_res.sample <= '0;
      if (mode == MODE_ON) begin
        note_res.voice     <= 6'(pick);
        note_res.voice_hit <= 1'b1;
      end else if (mode == MODE_OFF && srch.hit_found) begin
        note_res.voice     <= 6'(srch.hit_idx);
        note_res.voice_hit <= 1'b1;
      end else begin
        note_res.voice     <= '0;
        note_res.voice_hit <= 1'b0;
      end
    end
  end

  // Output word
  assign done = note_done || mix_vld;

  always_comb begin
    if (mix_vld) begin
      result        = '0;
      result.sample = mix_sample;
    end else begin
      result = note_res;
    end
  end

endmodule

// ----- rtl/core/pva_checker.sv -----
// ----------------------------------------------------------------------------
// pva_checker
// Port-level checks on the voice allocator: command/result pairing and
// the shape of result words.
// ----------------------------------------------------------------------------
module pva_checker
  import pva_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input logic     done,
  input pva_out_t result
);

  // A result word is shown for one cycle only
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held longer than one cycle");

  // An accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command accepted but block not busy");

  // The block only goes idle when it hands out a result
  a_idle_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) && !$past(rst) |-> done)
    else $error("busy fell without a result word");

  // Note results carry no sample
  a_hit_sample: assert property (@(posedge clk) disable iff (rst)
    done && result.voice_hit |-> result.sample == 16'sd0)
    else $error("note result with nonzero sample");

  // No voice reported without a hit
  a_nohit_voice: assert property (@(posedge clk) disable iff (rst)
    done && !result.voice_hit |-> result.voice == 6'd0)
    else $error("voice reported without a hit");

endmodule

bind polyphonic_voice_allocator_synth_core pva_checker u_pva_checker (.*);

// ----- tb/tb_polyphonic_voice_allocator_synth_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_polyphonic_voice_allocator_synth_core
// Self-checking bench for the voice allocator and sine mixer. A directed
// sequence walks through allocation, stealing, release and mixing. Random
// note and tick traffic follows under several output gain settings. Every
// result word is checked against a cycle-free model of the voice table.
// ----------------------------------------------------------------------------
module tb_polyphonic_voice_allocator_synth_core
  import pva_pkg::*;
;

  localparam int          CLK_HALF       = 5;
  localparam int          RAND_PER_PHASE = 170;
  localparam logic [1:0]  MODE_NONE      = 2'd3;
  localparam logic [15:0] GAIN_AT_RESET  = 16'd4096;

  // sin(pi/2 * t) coefficients in Q30, index 0 is the t^1 term
  localparam logic [4:0][31:0] POLY_Q30 = {
    32'd172272, 32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
  };
  // 2^(k/12) in Q16, index 0 is the unison
  localparam logic [11:0][31:0] SEMITONE_Q16 = {
    32'd123715, 32'd116772, 32'd110218, 32'd104032, 32'd98193, 32'd92682,
    32'd87480,  32'd82570,  32'd77936,  32'd73562,  32'd69433, 32'd65536
  };

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  pva_in_t            cmd     = '0;
  logic               busy;
  logic               done;
  pva_out_t           result;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  polyphonic_voice_allocator_synth_core DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Voice table mirror
  logic signed [15:0]    sine_rom   [SINE_ENTRIES];
  logic [PHASE_BITS-1:0] note_incr  [128];
  logic [6:0]            v_note     [VOICES];
  logic [63:0]           v_stamp    [VOICES];
  logic [PHASE_BITS-1:0] v_phase    [VOICES];
  logic [PHASE_BITS-1:0] v_incr     [VOICES];
  logic [63:0]           stamp_ctr;
  logic [15:0]           mix_gain;

  pva_in_t  pending_cmds[$];
  pva_out_t predicted_results[$];
  pva_out_t want_word;
  bit       no_gaps = 1'b0;

  int errors        = 0;
  int words_checked = 0;
  int n_on          = 0;
  int n_off         = 0;
  int n_tick        = 0;
  int n_other       = 0;
  int n_steal       = 0;
  int n_clip        = 0;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // round(32767 * sin(pi/2 * t)) for t in Q30, capped at full scale
  function automatic logic [15:0] quarter_wave(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] s;
    int          j;
    t2 = (t * t) >> 30;
    p  = 64'(POLY_Q30[4]);
    for (j = 3; j >= 0; j--) begin
      p = 64'(POLY_Q30[j]) - ((t2 * p) >> 30);
    end
    s = (t * p) >> 30;
    s = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[15:0];
  endfunction

  // Sine ROM and per-note phase increments
  function automatic void init_tables();
    logic [63:0] a;
    logic [63:0] quad;
    logic [63:0] rem;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [15:0] v;
    int          i;
    int          m;
    int          e;
    for (i = 0; i < SINE_ENTRIES; i++) begin
      a    = 64'(4 * i);
      quad = a / SINE_ENTRIES;
      rem  = a % SINE_ENTRIES;
      if (quad == 64'd1 || quad == 64'd3) begin
        rem = 64'(SINE_ENTRIES) - rem;
      end
      v           = quarter_wave((rem << 30) / SINE_ENTRIES);
      sine_rom[i] = (quad >= 64'd2) ? 16'(16'd0 - v) : v;
    end
    for (i = 0; i < 128; i++) begin
      m   = i + 3;
      num = 64'd440 * 64'(SEMITONE_Q16[m % 12]);
      den = 64'(SAMPLE_RATE);
      e   = m / 12 + PHASE_BITS - 22;
      if (e >= 0) begin
        num = num << e;
      end else begin
        den = den << (-e);
      end
      q            = (num + den / 2) / den;
      note_incr[i] = q[PHASE_BITS-1:0];
    end
  endfunction

  // Apply one command word to the mirror and return the result word
  function automatic pva_out_t apply_voice_cmd(input pva_in_t c);
    pva_out_t           r;
    int                 v;
    int                 pick;
    int                 same;
    int                 oldest;
    bit                 found;
    logic [63:0]        same_age;
    logic [63:0]        old_age;
    logic [63:0]        newest;
    logic [63:0]        idx;
    logic signed [31:0] acc;
    logic signed [63:0] prod;
    logic signed [63:0] q;
    r = '0;
    case (c.mode)
      MODE_ON: begin
        pick     = VOICES;
        same     = VOICES;
        oldest   = 0;
        found    = 1'b0;
        same_age = '1;
        old_age  = '1;
        for (v = 0; v < VOICES; v++) begin
          if (!found) begin
            if (v_stamp[v] == 64'd0) begin
              pick  = v;
              found = 1'b1;
            end else begin
              if (v_note[v] == c.note && v_stamp[v] < same_age) begin
                same_age = v_stamp[v];
                same     = v;
              end
              if (v_stamp[v] < old_age) begin
                old_age = v_stamp[v];
                oldest  = v;
              end
            end
          end
        end
        // table full: prefer the oldest voice already on this note
        if (!found) begin
          n_steal++;
          pick = (same != VOICES) ? same : oldest;
        end
        stamp_ctr     = stamp_ctr + 64'd1;
        v_note[pick]  = c.note;
        v_incr[pick]  = note_incr[c.note];
        v_stamp[pick] = stamp_ctr;
        v_phase[pick] = '0;
        r.voice       = 6'(pick);
        r.voice_hit   = 1'b1;
      end
      MODE_OFF: begin
        pick   = VOICES;
        newest = 64'd0;
        for (v = 0; v < VOICES; v++) begin
          if (v_note[v] == c.note && v_stamp[v] > newest) begin
            newest = v_stamp[v];
            pick   = v;
          end
        end
        if (pick != VOICES) begin
          v_stamp[pick] = 64'd0;
          r.voice       = 6'(pick);
          r.voice_hit   = 1'b1;
        end
      end
      MODE_TICK: begin
        acc = 0;
        for (v = 0; v < VOICES; v++) begin
          if (v_stamp[v] != 64'd0) begin
            idx        = ({32'd0, v_phase[v]} * SINE_ENTRIES) >> PHASE_BITS;
            acc        = acc + sine_rom[int'(idx)];
            v_phase[v] = v_phase[v] + v_incr[v];
          end
        end
        // floor division by 4096, then clamp
        prod = acc * $signed({48'd0, mix_gain});
        q    = prod >>> 12;
        if (q > SAT_HI) begin
          q = SAT_HI;
          n_clip++;
        end else if (q < SAT_LO) begin
          q = SAT_LO;
          n_clip++;
        end
        r.sample = q[15:0];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Command driver: holds start until the word is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predicted_results.push_back(apply_voice_cmd(cmd));
        case (cmd.mode)
          MODE_ON:   n_on++;
          MODE_OFF:  n_off++;
          MODE_TICK: n_tick++;
          default:   n_other++;
        endcase
      end
      if (!start || !busy) begin
        if (pending_cmds.size() != 0 && (no_gaps || $urandom_range(99) >= 17)) begin
          cmd   <= pending_cmds.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: one word per done strobe
  always @(posedge clk) begin
    if (!rst && done) begin
      if (predicted_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with none outstanding", result));
      end else begin
        want_word = predicted_results.pop_front();
        words_checked++;
        if (result.sample !== want_word.sample) begin
          report_mismatch($sformatf("word %0d sample got %0d want %0d", words_checked,
                                    $signed(result.sample), $signed(want_word.sample)));
        end
        if (result.voice !== want_word.voice) begin
          report_mismatch($sformatf("word %0d voice got %0d want %0d", words_checked,
                                    result.voice, want_word.voice));
        end
        if (result.voice_hit !== want_word.voice_hit) begin
          report_mismatch($sformatf("word %0d voice_hit got %b want %b", words_checked,
                                    result.voice_hit, want_word.voice_hit));
        end
      end
    end
  end

  // One APB transfer: setup, then access until pready
  task automatic apb_xfer(input logic wr, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_GAIN_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) begin
      @(negedge clk);
    end
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Read the gain back and compare with the mirror
  task automatic check_gain();
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b0, '0, rd);
    if (rd[GAIN_W-1:0] !== mix_gain) begin
      report_mismatch($sformatf("output_gain read %h want %h", rd[GAIN_W-1:0], mix_gain));
    end
  endtask

  task automatic set_gain(input logic [15:0] g);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, PDATA_W'(g), rd);
    mix_gain = g;
    check_gain();
  endtask

  task automatic push_cmd(input logic [1:0] mode, input logic [6:0] note);
    pva_in_t c;
    c.mode = mode;
    c.note = note;
    pending_cmds.push_back(c);
  endtask

  // Mostly well-formed play traffic on a narrow note pool, some noise
  task automatic fill_random(input int count);
    int         base;
    int         r;
    int         i;
    logic [6:0] pool_note;
    base = $urandom_range(116);
    for (i = 0; i < count; i++) begin
      r         = $urandom_range(99);
      pool_note = 7'(base + $urandom_range(11));
      if (r < 35) begin
        push_cmd(MODE_ON, pool_note);
      end else if (r < 60) begin
        push_cmd(MODE_OFF, pool_note);
      end else if (r < 88) begin
        push_cmd(MODE_TICK, 7'($urandom_range(127)));
      end else if (r < 94) begin
        push_cmd(MODE_NONE, 7'($urandom_range(127)));
      end else if (r < 97) begin
        push_cmd(MODE_ON, 7'($urandom_range(127)));
      end else begin
        push_cmd(MODE_OFF, 7'($urandom_range(127)));
      end
    end
  endtask

  // Block is idle once every issued word has come back; sampled mid-cycle
  // so that the driver's updates at the rising edge have settled
  task automatic drain();
    while (pending_cmds.size() != 0 || predicted_results.size() != 0 || start) begin
      @(negedge clk);
    end
  endtask

  // Main sequence
  initial begin
    logic [15:0] gain_plan [5];
    int          p;
    int          v;
    init_tables();
    for (v = 0; v < VOICES; v++) begin
      v_note[v]  = '0;
      v_stamp[v] = '0;
      v_phase[v] = '0;
      v_incr[v]  = '0;
    end
    stamp_ctr = '0;
    mix_gain  = GAIN_AT_RESET;
    gain_plan = '{16'hFFFF, 16'h0000, 16'($urandom), 16'd1, 16'($urandom)};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    check_gain();

    // directed: empty mix, unused mode, unmatched release, extremes
    push_cmd(MODE_TICK, 7'd0);
    push_cmd(MODE_NONE, 7'd127);
    push_cmd(MODE_OFF,  7'd60);
    push_cmd(MODE_ON,   7'd127);
    push_cmd(MODE_ON,   7'd0);
    push_cmd(MODE_TICK, 7'd127);
    push_cmd(MODE_TICK, 7'd0);
    push_cmd(MODE_OFF,  7'd127);
    push_cmd(MODE_OFF,  7'd127);
    // fill the table, then steal by same note and by age
    push_cmd(MODE_ON,   7'd69);
    push_cmd(MODE_ON,   7'd60);
    push_cmd(MODE_ON,   7'd60);
    push_cmd(MODE_ON,   7'd64);
    push_cmd(MODE_ON,   7'd67);
    push_cmd(MODE_ON,   7'd72);
    push_cmd(MODE_ON,   7'd76);
    push_cmd(MODE_ON,   7'd60);
    push_cmd(MODE_ON,   7'd100);
    // release picks the newest of duplicate notes
    push_cmd(MODE_OFF,  7'd60);
    push_cmd(MODE_TICK, 7'd5);
    push_cmd(MODE_TICK, 7'd64);
    push_cmd(MODE_TICK, 7'd31);
    push_cmd(MODE_TICK, 7'd96);
    push_cmd(MODE_NONE, 7'd0);
    push_cmd(MODE_TICK, 7'd127);
    drain();

    fill_random(RAND_PER_PHASE);
    drain();

    for (p = 0; p < 5; p++) begin
      set_gain(gain_plan[p]);
      no_gaps = (p == 2);
      fill_random(RAND_PER_PHASE);
      drain();
      no_gaps = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (predicted_results.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", predicted_results.size()));
    end
    $display("checked %0d words: %0d note-on (%0d steals), %0d note-off, %0d ticks, %0d unused",
             words_checked, n_on, n_steal, n_off, n_tick, n_other);
    $display("gain settings: reset, max, zero, one, two random; %0d clipped samples", n_clip);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- polyphonic_voice_allocator_synth_core.f -----
rtl/core/pva_pkg.sv
rtl/core/pva_ram.sv
rtl/core/pva_search.sv
rtl/core/pva_mix.sv
rtl/core/polyphonic_voice_allocator_synth_core.sv
rtl/core/pva_checker.sv
tb/tb_polyphonic_voice_allocator_synth_core.sv
